// ===== rtl/core/xsfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the XOR sprite framebuffer.
// No dependencies; rtl/core/xor_sprite_framebuffer.sv refers to it by scoped names.

package xsfb_pkg;

    // Default screen geometry
    localparam int SCREEN_ROWS_DEF = 32;
    localparam int SCREEN_COLS_DEF = 64;

    // Sprite byte width and the width of one row word on the read port
    localparam int SPRITE_W  = 8;
    localparam int RD_ROW_W  = 64;

    // Stream word widths (fields packed from bit 0 up, padded to bytes)
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    // Command codes carried in the input tuser
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_TOGGLE = 2'd3
    } t_cmd;

endpackage

// ===== rtl/core/xor_sprite_framebuffer.sv =====
`timescale 1ns / 1ps
// XOR sprite framebuffer top level: row memory, read-modify-write stage and output word.
// Depends on xsfb_pkg (rtl/core/xsfb_pkg.sv).
//
// Usage:
//   Input stream (i_s_*): one command word per handshake. tuser carries the command
//   (clear, draw sprite byte, read row, toggle pixel), tlast marks the final byte of a
//   sprite, tdata carries x_pos, y_pos, sprite_bits and sprite_row.
//   Output stream (o_m_*): exactly one result word per command, in command order.
//   tdata carries the collision flag and the 64-bit screen row, tlast echoes last_row
//   on draw (the collision flag is then final for that sprite).
//   Path: an accepted command enters stage 1, then its result goes to the output word.
//   Throughput: one command per cycle unless the receiver stalls. The row memory is
//   read when a command is accepted and written when it leaves stage 1; a command
//   accepted while its row is being written takes the new row from a forwarding
//   register instead. Clear drops the per-row valid bits, and a row with a cleared
//   valid bit reads as all zero.
//   Reset: synchronous, active low; clears the valid bits (so the whole screen), the
//   collision flag and both pipeline stages. No clearing pass is needed.
//   Stall: when the receiver holds tready low, the result word holds, the stage
//   behind it holds, and o_s_tready drops once both are full.

module xor_sprite_framebuffer #(
    parameter int SCREEN_ROWS = xsfb_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS = xsfb_pkg::SCREEN_COLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: x_pos[7:0], y_pos[15:8], sprite_bits[23:16], sprite_row[27:24], zero pad
    input  logic [xsfb_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]                         i_s_tuser,
    // tlast: last_row
    input  logic                               i_s_tlast,
    // Output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: collision[0], row_pixels[64:1], zero pad
    output logic [xsfb_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // tlast: sprite_done
    output logic                               o_m_tlast
);

    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int SUM_W  = ((ROW_W > 4) ? ROW_W : 4) + 1;
    localparam int CSUM_W = COL_W + 1;
    localparam int PAD_W  = xsfb_pkg::OUT_TDATA_W - xsfb_pkg::RD_ROW_W - 1;

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    logic [7:0]                      w_x;
    logic [7:0]                      w_y;
    logic [xsfb_pkg::SPRITE_W-1:0]   w_bits;
    logic [3:0]                      w_srow;
    xsfb_pkg::t_cmd                  w_cmd;

    assign w_x    = i_s_tdata[7:0];
    assign w_y    = i_s_tdata[15:8];
    assign w_bits = i_s_tdata[23:16];
    assign w_srow = i_s_tdata[27:24];
    assign w_cmd  = xsfb_pkg::t_cmd'(i_s_tuser);

    // ------------------------------------------------------------------
    // Wrap tables: coordinate modulo screen size, one entry per 8-bit value
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] w_ymod_tbl [256];
    logic [COL_W-1:0] w_xmod_tbl [256];

    for (genvar k = 0; k < 256; k++) begin : g_wrap_tbl
        assign w_ymod_tbl[k] = ROW_W'(k % SCREEN_ROWS);
        assign w_xmod_tbl[k] = COL_W'(k % SCREEN_COLS);
    end

    // ------------------------------------------------------------------
    // Stage 0: address and flip mask
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]       w_ymod;
    logic [SUM_W-1:0]       w_rsum;
    logic [SUM_W-1:0]       w_rsum1;
    logic [SUM_W-1:0]       w_rsum2;
    logic [ROW_W-1:0]       w_row;
    logic [COL_W-1:0]       w_c0;
    logic [CSUM_W-1:0]      w_csum;
    logic [SCREEN_COLS-1:0] w_mask;

    assign w_ymod  = w_ymod_tbl[w_y];
    assign w_rsum  = SUM_W'(w_ymod) + SUM_W'(w_srow);
    // Sum stays below SCREEN_ROWS + 15: two conditional subtracts suffice for 8 or more rows
    assign w_rsum1 = (w_rsum  >= SUM_W'(SCREEN_ROWS)) ? w_rsum  - SUM_W'(SCREEN_ROWS) : w_rsum;
    assign w_rsum2 = (w_rsum1 >= SUM_W'(SCREEN_ROWS)) ? w_rsum1 - SUM_W'(SCREEN_ROWS) : w_rsum1;
    assign w_row   = (w_cmd == xsfb_pkg::CMD_DRAW) ? w_rsum2[ROW_W-1:0] : w_ymod;
    assign w_c0    = w_xmod_tbl[w_x];

    always_comb begin
        w_mask = '0;
        w_csum = '0;
        if (w_cmd == xsfb_pkg::CMD_TOGGLE) begin
            w_mask[w_c0] = 1'b1;
        end else if (w_cmd == xsfb_pkg::CMD_DRAW) begin
            // Bit 7 of the sprite byte lands on the start column
            for (int j = 0; j < xsfb_pkg::SPRITE_W; j++) begin
                w_csum = CSUM_W'(w_c0) + CSUM_W'(j);
                if (w_csum >= CSUM_W'(SCREEN_COLS)) begin
                    w_csum = w_csum - CSUM_W'(SCREEN_COLS);
                end
                if (w_bits[xsfb_pkg::SPRITE_W-1-j]) begin
                    w_mask[w_csum[COL_W-1:0]] = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic                   r_s1_vld;
    xsfb_pkg::t_cmd         r_s1_cmd;
    logic [ROW_W-1:0]       r_s1_row;
    logic [SCREEN_COLS-1:0] r_s1_mask;
    logic                   r_s1_start;
    logic                   r_s1_last;
    logic                   r_fwd_en;
    logic [SCREEN_COLS-1:0] r_fwd_data;
    logic [SCREEN_COLS-1:0] r_mem_q;
    logic [SCREEN_ROWS-1:0] r_row_vld;
    logic                   r_hit;
    logic                   r_out_vld;
    logic [xsfb_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;

    logic w_s1_adv;
    logic w_in_acc;
    logic w_wr;
    logic w_s1_draw;

    assign w_s1_adv   = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || w_s1_adv;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_s1_draw  = (r_s1_cmd == xsfb_pkg::CMD_DRAW);
    assign w_wr       = w_s1_adv &&
                        ((r_s1_cmd == xsfb_pkg::CMD_DRAW) || (r_s1_cmd == xsfb_pkg::CMD_TOGGLE));

    // ------------------------------------------------------------------
    // Stage 1: modify
    // ------------------------------------------------------------------
    logic [SCREEN_COLS-1:0]          w_old;
    logic [SCREEN_COLS-1:0]          w_new;
    logic                            w_coll;
    logic [xsfb_pkg::RD_ROW_W-1:0]   w_rd;

    // Forwarded row wins, then an invalid (cleared) row reads as zero
    assign w_old  = r_fwd_en ? r_fwd_data : (r_row_vld[r_s1_row] ? r_mem_q : '0);
    assign w_new  = w_old ^ r_s1_mask;
    // A set pixel under a set mask bit goes dark: collision
    assign w_coll = (r_s1_start ? 1'b0 : r_hit) | (|(w_old & r_s1_mask));

    // Read word: column 0 in bit 63, columns past the screen read zero
    for (genvar c = 0; c < xsfb_pkg::RD_ROW_W; c++) begin : g_rd_map
        if (c < SCREEN_COLS) begin : g_on
            assign w_rd[xsfb_pkg::RD_ROW_W-1-c] = w_old[c];
        end else begin : g_off
            assign w_rd[xsfb_pkg::RD_ROW_W-1-c] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Row memory: one read port at accept, one write port at commit
    // ------------------------------------------------------------------
    logic [SCREEN_COLS-1:0] r_mem [SCREEN_ROWS];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_s1_row] <= w_new;
        end
        if (w_in_acc) begin
            r_mem_q <= r_mem[w_row];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 payload and forwarding capture
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cmd   <= w_cmd;
            r_s1_row   <= w_row;
            r_s1_mask  <= w_mask;
            r_s1_start <= (w_srow == 4'd0);
            r_s1_last  <= i_s_tlast;
            // Row being committed this cycle is not in the memory read yet
            r_fwd_en   <= w_s1_adv &&
                          ((r_s1_cmd == xsfb_pkg::CMD_CLEAR) || (w_wr && (r_s1_row == w_row)));
            r_fwd_data <= (r_s1_cmd == xsfb_pkg::CMD_CLEAR) ? '0 : w_new;
        end
    end

    // ------------------------------------------------------------------
    // Output word payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= {PAD_W'(0),
                           (r_s1_cmd == xsfb_pkg::CMD_READ) ? w_rd : '0,
                           w_s1_draw ? w_coll : 1'b0};
            r_out_last <= w_s1_draw && r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
            r_hit     <= 1'b0;
        end else begin
            // Advance stage 1, hold it while the output word is stalled
            if (w_in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            // Clear drops every row at once; a write marks its row live
            if (w_s1_adv && (r_s1_cmd == xsfb_pkg::CMD_CLEAR)) begin
                r_row_vld <= '0;
            end else if (w_wr) begin
                r_row_vld[r_s1_row] <= 1'b1;
            end
            if (w_s1_adv && w_s1_draw) begin
                r_hit <= w_coll;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_drops_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && (r_s1_cmd == xsfb_pkg::CMD_CLEAR)) |=> (r_row_vld == '0))
        else $error("clear left a live row");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s1_adv) |=> (r_s1_vld && $stable(r_s1_row) && $stable(r_s1_mask)))
        else $error("stage 1 changed while stalled");

    a_non_draw_flags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && !w_s1_draw) |=> (!o_m_tlast && !o_m_tdata[0]))
        else $error("flags set on a non-draw result");

    a_empty_start_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_s1_draw && r_s1_start && (r_s1_mask == '0)) |=> !o_m_tdata[0])
        else $error("collision on an empty first sprite byte");

    a_fwd_only_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_s1_adv && w_wr && (r_s1_row == w_row)) |=> r_fwd_en)
        else $error("missed forwarding of a committed row");

endmodule

// ===== bench/xor_sprite_framebuffer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for xor_sprite_framebuffer: drives command words, mirrors the
// screen and collision flag in a local model, and checks every result word in order.
// Depends on xsfb_pkg and the top level in rtl/core.

module xor_sprite_framebuffer_tb;

    localparam int ROWS        = xsfb_pkg::SCREEN_ROWS_DEF;
    localparam int COLS        = xsfb_pkg::SCREEN_COLS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 1000;

    // Expected contents of one result word
    typedef struct packed {
        logic        collision;
        logic        sprite_done;
        logic [63:0] row_pixels;
    } t_frame_result;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    // tdata: x_pos[7:0], y_pos[15:8], sprite_bits[23:16], sprite_row[27:24], zero pad
    logic [xsfb_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;
    // tuser: cmd[1:0]
    logic [1:0]               i_s_tuser  = xsfb_pkg::CMD_CLEAR;
    // tlast: last_row
    logic                     i_s_tlast  = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    // tdata: collision[0], row_pixels[64:1], zero pad
    logic [xsfb_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    // tlast: sprite_done
    logic                     o_m_tlast;

    // Local copy of the screen: bit 63 of a row is column 0
    logic [63:0]   screen_rows [ROWS];
    logic          sprite_hit;
    t_frame_result pending_results [$];

    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    int  words_sent    = 0;
    int  mismatch_count = 0;
    int  cycle_count   = 0;
    int  hold_left     = 0;
    logic hold_start   = 1'b0;

    xor_sprite_framebuffer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Long receiver hold-off: arm on a one-cycle pulse, then count down
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: stall at random, and hard during a hold-off
    always @(posedge i_clk) begin
        i_m_tready <= (hold_left == 0) && !hold_start &&
                      ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Apply one command to the local screen and return the word it should produce
    function automatic t_frame_result apply_command(xsfb_pkg::t_cmd cmd, logic [7:0] x_pos,
                                                    logic [7:0] y_pos, logic [7:0] sprite_bits,
                                                    logic [3:0] sprite_row, logic last_row);
        t_frame_result res;
        int row;
        int col0;
        int col;
        int r;
        int c;
        res = '0;
        case (cmd)
            xsfb_pkg::CMD_CLEAR: begin
                for (r = 0; r < ROWS; r++) screen_rows[r] = '0;
            end
            xsfb_pkg::CMD_DRAW: begin
                row  = ((int'(y_pos) % ROWS) + int'(sprite_row)) % ROWS;
                col0 = int'(x_pos) % COLS;
                // A sprite start drops the flag before the byte lands
                if (sprite_row == 4'd0) sprite_hit = 1'b0;
                for (c = 0; c < xsfb_pkg::SPRITE_W; c++) begin
                    if (sprite_bits[7 - c]) begin
                        col = (col0 + c) % COLS;
                        screen_rows[row][63 - col] = ~screen_rows[row][63 - col];
                        if (!screen_rows[row][63 - col]) sprite_hit = 1'b1;
                    end
                end
                res.collision   = sprite_hit;
                res.sprite_done = last_row;
            end
            xsfb_pkg::CMD_READ: begin
                res.row_pixels = screen_rows[int'(y_pos) % ROWS];
            end
            default: begin
                row = int'(y_pos) % ROWS;
                col = int'(x_pos) % COLS;
                screen_rows[row][63 - col] = ~screen_rows[row][63 - col];
            end
        endcase
        return res;
    endfunction

    // Offer one word after a random gap, hold it until taken, then predict its result
    task automatic send_word(xsfb_pkg::t_cmd cmd, logic [7:0] x_pos, logic [7:0] y_pos,
                             logic [7:0] sprite_bits, logic [3:0] sprite_row, logic last_row);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {4'b0000, sprite_row, sprite_bits, y_pos, x_pos};
        i_s_tlast  <= last_row;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(apply_command(cmd, x_pos, y_pos, sprite_bits,
                                                sprite_row, last_row));
        words_sent++;
    endtask

    // Pick one random piece of traffic; mostly whole sprites so collisions build up
    task automatic send_random_traffic();
        int pick;
        int rows;
        int r;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        pick  = $urandom_range(0, 99);
        x_pos = 8'($urandom_range(0, 255));
        y_pos = 8'($urandom_range(0, 255));
        if (pick < 55) begin
            rows = $urandom_range(1, 16);
            for (r = 0; r < rows; r++) begin
                send_word(xsfb_pkg::CMD_DRAW, x_pos, y_pos, 8'($urandom_range(0, 255)),
                          4'(r), r == rows - 1);
            end
        end else if (pick < 80) begin
            send_word(xsfb_pkg::CMD_READ, x_pos, y_pos, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else if (pick < 92) begin
            send_word(xsfb_pkg::CMD_TOGGLE, x_pos, y_pos, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else if (pick < 95) begin
            send_word(xsfb_pkg::CMD_CLEAR, x_pos, y_pos, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else begin
            // Stray sprite byte: any row offset, any last flag
            send_word(xsfb_pkg::CMD_DRAW, x_pos, y_pos, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Empty screen after reset, single pixel flips, coordinate wrap, clear
    task automatic test_pixels_and_clear();
        send_word(xsfb_pkg::CMD_READ,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0);
        send_word(xsfb_pkg::CMD_READ,   8'd0,   8'd255, 8'h00, 4'd0, 1'b0);
        send_word(xsfb_pkg::CMD_TOGGLE, 8'd0,   8'd0,   8'h00, 4'd0, 1'b0);
        send_word(xsfb_pkg::CMD_TOGGLE, 8'd255, 8'd255, 8'hFF, 4'd15, 1'b1);
        send_word(xsfb_pkg::CMD_TOGGLE, 8'd65,  8'd32,  8'h00, 4'd0, 1'b0);
        send_word(xsfb_pkg::CMD_READ,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0);
        send_word(xsfb_pkg::CMD_READ,   8'd7,   8'd31,  8'h00, 4'd0, 1'b1);
        send_word(xsfb_pkg::CMD_CLEAR,  8'd0,   8'd0,   8'h00, 4'd0, 1'b0);
        send_word(xsfb_pkg::CMD_READ,   8'd0,   8'd31,  8'h00, 4'd0, 1'b0);
    endtask

    // Collision flag: set, restart on row zero, kept across other commands and
    // across sprite bytes that do not start a sprite, zero bytes, edge wrap
    task automatic test_sprite_collision();
        send_word(xsfb_pkg::CMD_DRAW,   8'd60,  8'd5,   8'hFF, 4'd0,  1'b0);
        send_word(xsfb_pkg::CMD_DRAW,   8'd60,  8'd4,   8'h81, 4'd1,  1'b1);
        send_word(xsfb_pkg::CMD_READ,   8'd0,   8'd5,   8'h00, 4'd0,  1'b0);
        send_word(xsfb_pkg::CMD_DRAW,   8'd0,   8'd5,   8'h00, 4'd0,  1'b1);
        send_word(xsfb_pkg::CMD_DRAW,   8'd61,  8'd5,   8'h80, 4'd0,  1'b0);
        send_word(xsfb_pkg::CMD_TOGGLE, 8'd9,   8'd9,   8'h00, 4'd0,  1'b0);
        send_word(xsfb_pkg::CMD_READ,   8'd0,   8'd5,   8'h00, 4'd0,  1'b0);
        send_word(xsfb_pkg::CMD_CLEAR,  8'd0,   8'd0,   8'h00, 4'd0,  1'b0);
        send_word(xsfb_pkg::CMD_DRAW,   8'd0,   8'd2,   8'h00, 4'd3,  1'b1);
        send_word(xsfb_pkg::CMD_DRAW,   8'd255, 8'd255, 8'hFF, 4'd15, 1'b1);
        send_word(xsfb_pkg::CMD_READ,   8'd0,   8'd46,  8'h00, 4'd0,  1'b0);
        send_word(xsfb_pkg::CMD_DRAW,   8'd0,   8'd0,   8'hFF, 4'd0,  1'b0);
    endtask

    // Random traffic at one idle setting
    task automatic test_random_traffic(int src_pct, int sink_pct, int word_count);
        int start;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start = words_sent;
        while (words_sent - start < word_count) send_random_traffic();
    endtask

    // Hold the receiver off while words keep coming, so the input stalls
    task automatic test_backpressure();
        int start;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // Drop the last word so it is not taken twice while the hold-off arms
        i_s_tvalid <= 1'b0;
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        start = words_sent;
        while (words_sent - start < 40) send_random_traffic();
    endtask

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: tdata=%h tlast=%b", o_m_tdata, o_m_tlast);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[0] !== want.collision || o_m_tlast !== want.sprite_done ||
                    o_m_tdata[64:1] !== want.row_pixels) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: want coll=%b done=%b row=%h, ",
                                  "got coll=%b done=%b row=%h"},
                                 want.collision, want.sprite_done, want.row_pixels,
                                 o_m_tdata[0], o_m_tlast, o_m_tdata[64:1]);
                end
            end
        end
    end

    initial begin : run_tests
        int r;
        for (r = 0; r < ROWS; r++) screen_rows[r] = '0;
        sprite_hit = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pixels_and_clear();
        test_sprite_collision();
        test_backpressure();
        test_random_traffic(8, 86, RANDOM_WORDS / 3);
        test_random_traffic(86, 8, RANDOM_WORDS / 3);
        test_random_traffic(0, 0, RANDOM_WORDS / 3);

        // Drain: stop offering words and wait out every pending result
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== xor_sprite_framebuffer.f =====
rtl/core/xsfb_pkg.sv
rtl/core/xor_sprite_framebuffer.sv
bench/xor_sprite_framebuffer_tb.sv
